@@ hdl/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg: shared types, constants and microcode for the integer-to-ASCII block
// Holds the control word layout, the step program and the character tables.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Datapath sizing
  localparam int VALUE_WIDTH_DEF = 64;
  localparam int IN_WIDTH        = 64;   // width of the value field
  localparam int DIGITS          = 20;   // decimal digits of a 64-bit magnitude
  localparam int DIGIT_BITS      = DIGITS * 4;
  localparam int DCNT_W          = $clog2(DIGITS + 1);
  localparam int STEP_W          = 4;

  // Input format codes
  localparam logic [1:0] FUNC_SIGNED   = 2'd0;
  localparam logic [1:0] FUNC_UNSIGNED = 2'd1;
  localparam logic [1:0] FUNC_HEX      = 2'd2;

  // ASCII characters
  localparam logic [7:0] ASCII_MINUS = 8'h2d;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_X     = 8'h78;

  localparam logic [7:0] HEX_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef logic [STEP_W-1:0] step_t;

  // Character source for an emit step
  typedef enum logic [1:0] {
    CH_ZERO,
    CH_X,
    CH_MINUS,
    CH_DIGIT
  } char_sel_e;

  // Datapath operation
  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_DABBLE,
    DP_SKIP,
    DP_SHIFT
  } dp_op_e;

  // Jump condition
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_IS_DEC,
    C_NOT_NEG,
    C_BITS_LEFT,
    C_LEAD_ZERO,
    C_MORE_DIGITS
  } cond_e;

  // One control word of the program
  typedef struct packed {
    logic      accept;
    logic      emit;
    char_sel_e chr;
    dp_op_e    op;
    cond_e     cond;
    step_t     target;
  } ctrl_t;

  // Program step addresses
  localparam step_t ST_FETCH   = 4'd0;
  localparam step_t ST_FORMAT  = 4'd1;
  localparam step_t ST_HEX0    = 4'd2;
  localparam step_t ST_HEXX    = 4'd3;
  localparam step_t ST_SIGN    = 4'd4;
  localparam step_t ST_MINUS   = 4'd5;
  localparam step_t ST_CONVERT = 4'd6;
  localparam step_t ST_SKIP    = 4'd7;
  localparam step_t ST_EMIT    = 4'd8;
  localparam step_t ST_RET     = 4'd9;

  // Microcode ROM
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t cw;
    cw = '{accept: 1'b0, emit: 1'b0, chr: CH_DIGIT, op: DP_NOP,
           cond: C_ALWAYS, target: ST_FETCH};
    case (step)
      ST_FETCH: begin
        cw.accept = 1'b1;
        cw.op     = DP_LOAD;
        cw.cond   = C_NO_INPUT;
        cw.target = ST_FETCH;
      end
      ST_FORMAT: begin
        cw.cond   = C_IS_DEC;
        cw.target = ST_SIGN;
      end
      ST_HEX0: begin
        cw.emit = 1'b1;
        cw.chr  = CH_ZERO;
        cw.cond = C_NEVER;
      end
      ST_HEXX: begin
        cw.emit   = 1'b1;
        cw.chr    = CH_X;
        cw.target = ST_SKIP;
      end
      ST_SIGN: begin
        cw.cond   = C_NOT_NEG;
        cw.target = ST_CONVERT;
      end
      ST_MINUS: begin
        cw.emit = 1'b1;
        cw.chr  = CH_MINUS;
        cw.cond = C_NEVER;
      end
      ST_CONVERT: begin
        cw.op     = DP_DABBLE;
        cw.cond   = C_BITS_LEFT;
        cw.target = ST_CONVERT;
      end
      ST_SKIP: begin
        cw.op     = DP_SKIP;
        cw.cond   = C_LEAD_ZERO;
        cw.target = ST_SKIP;
      end
      ST_EMIT: begin
        cw.emit   = 1'b1;
        cw.chr    = CH_DIGIT;
        cw.op     = DP_SHIFT;
        cw.cond   = C_MORE_DIGITS;
        cw.target = ST_EMIT;
      end
      ST_RET: begin
        cw.target = ST_FETCH;
      end
      default: begin
        cw.target = ST_FETCH;
      end
    endcase
    return cw;
  endfunction

endpackage

@@ hdl/itoa_stream_if.sv @@
// ----------------------------------------------------------------------------
// itoa_stream_if: valid/ready channels of the integer-to-ASCII block
// Request channel (format and value) and character channel (char and last).
// ----------------------------------------------------------------------------
interface itoa_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      func;
  logic [itoa_pkg::IN_WIDTH-1:0]   value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface itoa_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

@@ hdl/integer_to_ascii_converter.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_converter: 64-bit integer to ASCII text, one char per transfer
// Microcoded sequencer: signed/unsigned decimal via shift-add-3, or 0x hex.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload           accepted when
//  req_i    in   func, value       valid && ready
//  txt_o    out  out_char, last    valid && ready
//
// A decimal request runs fetch, format and sign steps, a minus step when a
// minus sign is printed, one shift-add-3 step per magnitude bit, leading-zero
// skip plus digit emit, and a return step. A hex request runs fetch, format,
// the 0 and x emit steps, skip, emit and return. The step program runs one
// control word per cycle unless an emit step stalls. Reset clears the step
// counter and output valid. An emit step holds the whole sequencer while the
// output register is full and not taken; ready is high only at the fetch step.
//
module integer_to_ascii_converter #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  itoa_req_if.sink          req_i,
  itoa_char_if.source       txt_o
);

  localparam int BCNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int DB     = itoa_pkg::DIGIT_BITS;

  // Sequencer state
  itoa_pkg::step_t step_q, step_d;
  itoa_pkg::ctrl_t cw;

  // Datapath registers
  logic [VALUE_WIDTH-1:0]       mag_q, mag_d;
  logic [DB-1:0]                bcd_q, bcd_d;
  logic [BCNT_W-1:0]            bcnt_q, bcnt_d;
  logic [itoa_pkg::DCNT_W-1:0]  dcnt_q, dcnt_d;
  logic                         hex_q, hex_d;
  logic                         neg_q, neg_d;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;

  logic                   run;
  logic                   cond_true;
  logic                   lead_zero;
  logic [3:0]             top_digit;
  logic [VALUE_WIDTH-1:0] in_val;
  logic                   in_neg;
  logic [DB-1:0]          bcd_adj;

  assign cw        = itoa_pkg::ucode(step_q);
  assign top_digit = bcd_q[DB-1 -: 4];
  assign lead_zero = (top_digit == 4'd0) && (dcnt_q != itoa_pkg::DCNT_W'(1));
  assign in_val    = req_i.value[VALUE_WIDTH-1:0];
  assign in_neg    = (req_i.func == itoa_pkg::FUNC_SIGNED) && in_val[VALUE_WIDTH-1];

  // Stall emit steps while the output register is occupied and not taken
  assign run = !cw.emit || !out_valid_q || txt_o.ready;

  assign req_i.ready    = cw.accept;
  assign txt_o.valid    = out_valid_q;
  assign txt_o.out_char = out_char_q;
  assign txt_o.last     = out_last_q;

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < itoa_pkg::DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  // Jump condition select
  always_comb begin
    case (cw.cond)
      itoa_pkg::C_NEVER:       cond_true = 1'b0;
      itoa_pkg::C_ALWAYS:      cond_true = 1'b1;
      itoa_pkg::C_NO_INPUT:    cond_true = !req_i.valid;
      itoa_pkg::C_IS_DEC:      cond_true = !hex_q;
      itoa_pkg::C_NOT_NEG:     cond_true = !neg_q;
      itoa_pkg::C_BITS_LEFT:   cond_true = (bcnt_q != BCNT_W'(1));
      itoa_pkg::C_LEAD_ZERO:   cond_true = lead_zero;
      itoa_pkg::C_MORE_DIGITS: cond_true = (dcnt_q != itoa_pkg::DCNT_W'(1));
      default:                 cond_true = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    step_d = step_q;
    if (run) begin
      step_d = cond_true ? cw.target : itoa_pkg::step_t'(step_q + 1'b1);
    end
  end

  // Datapath operations
  always_comb begin
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    bcnt_d = bcnt_q;
    dcnt_d = dcnt_q;
    hex_d  = hex_q;
    neg_d  = neg_q;
    if (run) begin
      case (cw.op)
        itoa_pkg::DP_LOAD: begin
          if (req_i.valid) begin
            hex_d  = req_i.func[1];
            neg_d  = in_neg;
            mag_d  = in_neg ? (~in_val + 1'b1) : in_val;
            bcd_d  = req_i.func[1] ? DB'(in_val) : '0;
            bcnt_d = BCNT_W'(VALUE_WIDTH);
            dcnt_d = itoa_pkg::DCNT_W'(itoa_pkg::DIGITS);
          end
        end
        itoa_pkg::DP_DABBLE: begin
          bcd_d  = {bcd_adj[DB-2:0], mag_q[VALUE_WIDTH-1]};
          mag_d  = {mag_q[VALUE_WIDTH-2:0], 1'b0};
          bcnt_d = bcnt_q - 1'b1;
        end
        itoa_pkg::DP_SKIP: begin
          if (lead_zero) begin
            bcd_d  = {bcd_q[DB-5:0], 4'd0};
            dcnt_d = dcnt_q - 1'b1;
          end
        end
        itoa_pkg::DP_SHIFT: begin
          bcd_d  = {bcd_q[DB-5:0], 4'd0};
          dcnt_d = dcnt_q - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register load and drain
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (out_valid_q && txt_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (cw.emit && run) begin
      out_valid_d = 1'b1;
      out_last_d  = 1'b0;
      case (cw.chr)
        itoa_pkg::CH_ZERO:  out_char_d = itoa_pkg::ASCII_ZERO;
        itoa_pkg::CH_X:     out_char_d = itoa_pkg::ASCII_X;
        itoa_pkg::CH_MINUS: out_char_d = itoa_pkg::ASCII_MINUS;
        itoa_pkg::CH_DIGIT: begin
          out_char_d = itoa_pkg::HEX_CHARS[top_digit];
          out_last_d = (dcnt_q == itoa_pkg::DCNT_W'(1));
        end
        default: out_char_d = itoa_pkg::ASCII_ZERO;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= itoa_pkg::ST_FETCH;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    bcnt_q     <= bcnt_d;
    dcnt_q     <= dcnt_d;
    hex_q      <= hex_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

endmodule

@@ sim/itoa_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// itoa_checker: scoreboard for the integer-to-ASCII converter
// Watches the request and character channels. For every accepted request it
// predicts the text that the block must print and compares each accepted
// character, in order, with the oldest predicted one.
// ----------------------------------------------------------------------------
module itoa_checker
  import itoa_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  itoa_req_if   req,
  itoa_char_if  txt,
  output int    errors_o,
  output int    pending_o
);

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;

  // One predicted character, tagged with the request it belongs to
  typedef struct {
    logic [7:0] ch;
    logic       last;
    int         req_num;
  } text_char_t;

  text_char_t text_q [$];
  int         fail_count = 0;
  int         req_count  = 0;

  assign errors_o = fail_count;

  task automatic report_err(input string msg);
    $display("itoa_checker: mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // Predict the full text of one request and queue it, last character marked
  function automatic void predict_text(input logic [1:0] f,
                                       input logic [IN_WIDTH-1:0] raw);
    logic [IN_WIDTH-1:0] mask;
    logic [IN_WIDTH-1:0] v;
    logic [IN_WIDTH-1:0] mag;
    logic [IN_WIDTH-1:0] radix;
    logic [7:0]          chars [$];
    logic [7:0]          digits [$];
    int                  d;
    mask = {IN_WIDTH{1'b1}} >> (IN_WIDTH - VALUE_WIDTH);
    v    = raw & mask;
    radix = 64'd10;
    mag   = v;
    // code 3 is not defined; the high bit alone selects hex
    if (f[1]) begin
      chars.push_back(ASCII_ZERO);
      chars.push_back(ASCII_X);
      radix = 64'd16;
    end else if (f == FUNC_SIGNED && v[VALUE_WIDTH-1]) begin
      // magnitude taken as unsigned, so the most negative value is exact
      chars.push_back(ASCII_MINUS);
      mag = (~v + 1'b1) & mask;
    end
    do begin
      d   = int'(mag % radix);
      mag = mag / radix;
      digits.push_front(d < 10 ? ASCII_ZERO + 8'(d) : ASCII_UPPER_A + 8'(d - 10));
    end while (mag != 0);
    foreach (digits[k]) chars.push_back(digits[k]);
    foreach (chars[k])
      text_q.push_back('{ch: chars[k], last: (k == chars.size() - 1), req_num: req_count});
  endfunction

  // Compare accepted characters, then predict for an accepted request
  always @(posedge clk_i) begin : watch
    text_char_t want;
    if (rst_ni) begin
      if (txt.valid && txt.ready) begin
        if (text_q.size() == 0) begin
          report_err($sformatf("char %h last %b with nothing pending",
                               txt.out_char, txt.last));
        end else begin
          want = text_q.pop_front();
          if (txt.out_char !== want.ch)
            report_err($sformatf("request %0d: char %h, predicted %h",
                                 want.req_num, txt.out_char, want.ch));
          if (txt.last !== want.last)
            report_err($sformatf("request %0d: last %b, predicted %b",
                                 want.req_num, txt.last, want.last));
        end
      end
      if (req.valid && req.ready) begin
        predict_text(req.func, req.value);
        req_count++;
      end
    end
    pending_o <= text_q.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top-level testbench of the integer-to-ASCII converter
// Sends directed and random format/value requests in bursts, stalls the
// character channel on shifting patterns, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
  import itoa_pkg::*;

  localparam int         CYCLE_LIMIT  = 400_000;
  localparam int         HOLD_CYCLES  = 600;
  localparam int         END_SLACK    = 120;
  localparam int         RANDOM_ITEMS = 160;
  localparam logic [1:0] FUNC_SPARE   = 2'd3;

  // Receiver stall patterns and random value shapes
  typedef enum {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_COMB} rx_mode_e;
  typedef enum {SH_FULL, SH_SHORT, SH_NEG, SH_POW10, SH_EDGE} shape_e;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  int   burst_left;
  int   cycles;
  bit   hold_off;

  itoa_req_if  req_if ();
  itoa_char_if txt_if ();

  integer_to_ascii_converter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .txt_o  (txt_if)
  );

  itoa_checker CHECK (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_if),
    .txt       (txt_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one request until taken; drop valid for a gap at the end of a burst
  task automatic offer_number(input logic [1:0] f, input logic [IN_WIDTH-1:0] v);
    req_if.valid <= 1'b1;
    req_if.func  <= f;
    req_if.value <= v;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(40, 150) : $urandom_range(1, 30))
        @(posedge clk_i);
      burst_left = $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Stop sending and wait until every predicted character has come out
  task automatic drain_text();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Character channel: changing stall patterns, and one long hold-off on demand
  initial begin : receiver
    rx_mode_e mode;
    int       span;
    span = 0;
    mode = RX_STEADY;
    txt_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        txt_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        if (span == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          span = $urandom_range(16, 120);
        end
        span--;
        case (mode)
          RX_STEADY: txt_if.ready <= 1'b1;
          RX_LIGHT:  txt_if.ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY:  txt_if.ready <= ($urandom_range(0, 3) == 0);
          RX_COMB:   txt_if.ready <= (span % 5 < 2);
          default:   txt_if.ready <= 1'b1;
        endcase
      end
    end
  end

  // Run limit
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic [IN_WIDTH-1:0] raw;
    logic [IN_WIDTH-1:0] v;
    logic [1:0]          f;
    int                  r;
    hold_off     = 1'b0;
    burst_left   = 3;
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.func  <= FUNC_SIGNED;
    req_if.value <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero, extremes, most negative, every format and the spare code
    offer_number(FUNC_SIGNED,   64'd0);
    offer_number(FUNC_SIGNED,   64'd1);
    offer_number(FUNC_SIGNED,   {64{1'b1}});
    offer_number(FUNC_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF);
    offer_number(FUNC_SIGNED,   64'h8000_0000_0000_0000);
    offer_number(FUNC_SIGNED,   -64'sd10);
    offer_number(FUNC_SIGNED,   64'd1234567890);
    offer_number(FUNC_UNSIGNED, 64'd0);
    offer_number(FUNC_UNSIGNED, 64'd9);
    offer_number(FUNC_UNSIGNED, {64{1'b1}});
    offer_number(FUNC_UNSIGNED, 64'd10_000_000_000_000_000_000);
    offer_number(FUNC_UNSIGNED, 64'h8000_0000_0000_0000);
    offer_number(FUNC_HEX,      64'd0);
    offer_number(FUNC_HEX,      64'hA);
    offer_number(FUNC_HEX,      {64{1'b1}});
    offer_number(FUNC_HEX,      64'h0123_4567_89AB_CDEF);
    offer_number(FUNC_HEX,      64'h8000_0000_0000_0000);
    offer_number(FUNC_SPARE,    64'hDEAD_BEEF);
    offer_number(FUNC_SPARE,    64'd0);
    drain_text();

    // Random: mixed formats, values shaped to reach every digit count
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 40) hold_off = 1'b1;
      if (i == 100) drain_text();
      r = $urandom_range(0, 15);
      f = (r < 5) ? FUNC_SIGNED : (r < 10) ? FUNC_UNSIGNED : (r < 15) ? FUNC_HEX : FUNC_SPARE;
      raw = {$urandom, $urandom};
      case (shape_e'($urandom_range(0, 4)))
        SH_FULL:  v = raw;
        SH_SHORT: v = raw >> $urandom_range(1, 63);
        SH_NEG:   v = -(raw >> $urandom_range(1, 63));
        SH_POW10: begin
          v = 64'd1;
          repeat ($urandom_range(0, 19)) v = v * 64'd10;
          v = v + 64'($urandom_range(0, 2)) - 64'd1;
        end
        SH_EDGE:  v = {raw[63], {63{raw[62]}}} ^ 64'(raw[3:0]);
        default:  v = raw;
      endcase
      offer_number(f, v);
    end
    drain_text();
    repeat (END_SLACK) @(posedge clk_i);

    if (errors == 0 && pending == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
